// ----- hdl/cmap_rc_pkg.sv -----
// cmap_rc_pkg: shared types and constants for the cmap range clipper
// used by cmap_rc_cell and cmap_range_clipper_core; no dependencies
`default_nettype none

package cmap_rc_pkg;

    localparam int DELETE_RANGES_DEF = 16;

    localparam int CP_W    = 21;
    localparam int GLYPH_W = 32;
    localparam int RO_W    = 16;
    localparam int FUNC_W  = 2;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_CLIP12 = 2'd2,
        FUNC_CLIP4  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_TAIL,
        ST_FINAL
    } walk_state_t;

    typedef struct packed {
        logic [CP_W-1:0] last_cp;
        logic [CP_W-1:0] first_cp;
    } range_ent_t;

    typedef struct packed {
        logic ins;
        logic rot;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/cmap_rc_cell.sv -----
// cmap_rc_cell: one slot of the sorted deletion range chain
// depends on cmap_rc_pkg; takes part in sorted insert and in rotation toward slot 0
`default_nettype none

module cmap_rc_cell (
    input  wire logic                    clk,
    input  wire cmap_rc_pkg::cell_ctl_t  ctl,
    input  wire cmap_rc_pkg::range_ent_t new_ent,
    input  wire cmap_rc_pkg::range_ent_t prev_ent,
    input  wire logic                    prev_valid,
    input  wire logic                    prev_gt,
    input  wire cmap_rc_pkg::range_ent_t next_ent,
    input  wire logic                    valid,
    output cmap_rc_pkg::range_ent_t      ent,
    output logic                         gt
);
    import cmap_rc_pkg::*;

    range_ent_t ent_reg;
    range_ent_t ent_next;

    // entry sorts after the new range
    assign gt  = valid && (ent_reg.first_cp > new_ent.first_cp);
    assign ent = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.rot)
        begin
            ent_next = next_ent;
        end
        else if (ctl.ins)
        begin
            if (prev_valid && prev_gt)
            begin
                ent_next = prev_ent;
            end
            else if (prev_valid && (!valid || gt))
            begin
                // first slot that is empty or sorts after the new range
                ent_next = new_ent;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

// ----- hdl/cmap_range_clipper_core.sv -----
// cmap_range_clipper_core: top level, subtracts stored deletion ranges from cmap segments
// depends on cmap_rc_pkg and cmap_rc_cell
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: item fields, tuser: func
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: piece fields, tuser: flags, tlast
//
// clear and add finish in the idle state; a clip rotates the whole range chain through
// slot 0, one entry per cycle unless the output stalls, then takes tail and final steps
// reset clears the range count, the walk state and the output register; entries need no reset
// a stalled output transaction holds the walk; the next item enters only when the output
// register is empty or hands its transaction over in the same cycle
`default_nettype none

module cmap_range_clipper_core #(
    parameter int DELETE_RANGES = cmap_rc_pkg::DELETE_RANGES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // seg_start, seg_end, glyph_or_delta, range_offset, zero pad
    input  wire logic [cmap_rc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func
    input  wire logic [cmap_rc_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // piece_start, piece_end, piece_glyph_or_delta, piece_range_offset, zero pad
    output logic [cmap_rc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // kept, dropped
    output logic [cmap_rc_pkg::OUT_USER_W-1:0]       m_axis_tuser,
    output logic                                     m_axis_tlast
);
    import cmap_rc_pkg::*;

    localparam int N  = DELETE_RANGES;
    localparam int CW = $clog2(N + 1);

    // input unpack
    logic [CP_W-1:0]    in_start;
    logic [CP_W-1:0]    in_end;
    logic [GLYPH_W-1:0] in_glyph;
    logic [RO_W-1:0]    in_ro;
    func_t              in_func;
    logic               in_accept;
    logic               can_emit;

    assign in_start  = s_axis_tdata[CP_W-1:0];
    assign in_end    = s_axis_tdata[2*CP_W-1:CP_W];
    assign in_glyph  = s_axis_tdata[2*CP_W+GLYPH_W-1:2*CP_W];
    assign in_ro     = s_axis_tdata[2*CP_W+GLYPH_W+RO_W-1:2*CP_W+GLYPH_W];
    assign in_func   = func_t'(s_axis_tuser);

    // state
    walk_state_t        state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CP_W:0]      cur_reg, cur_next;
    logic               done_reg, done_next;
    func_t              func_reg, func_next;
    logic [CP_W-1:0]    s_reg, s_next;
    logic [CP_W-1:0]    e_reg, e_next;
    logic [GLYPH_W-1:0] g_reg, g_next;
    logic [RO_W-1:0]    ro_reg, ro_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [CP_W-1:0]    pend_start_reg, pend_start_next;
    logic [CP_W-1:0]    pend_end_reg, pend_end_next;
    logic [GLYPH_W-1:0] pend_glyph_reg, pend_glyph_next;
    logic [RO_W-1:0]    pend_ro_reg, pend_ro_next;

    logic               out_valid_reg, out_valid_next;
    logic [CP_W-1:0]    out_start_reg, out_start_next;
    logic [CP_W-1:0]    out_end_reg, out_end_next;
    logic [GLYPH_W-1:0] out_glyph_reg, out_glyph_next;
    logic [RO_W-1:0]    out_ro_reg, out_ro_next;
    logic               out_kept_reg, out_kept_next;
    logic               out_last_reg, out_last_next;
    logic               out_drop_reg, out_drop_next;

    logic               full;
    cell_ctl_t          cell_ctl;
    range_ent_t         new_ent;
    range_ent_t         ent [N];
    logic               gt [N];
    logic               valid [N];

    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && can_emit;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CW'(N));

    assign new_ent.first_cp = in_start;
    assign new_ent.last_cp  = in_end;
    assign cell_ctl.ins     = in_accept && (in_func == FUNC_ADD) && !full;
    assign cell_ctl.rot     = (state_reg == ST_WALK) && can_emit;

    // chain of range cells, slot 0 is the head seen by the walk
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        assign valid[i] = (CW'(i) < count_reg);
        if (i == 0)
        begin : g_head
            cmap_rc_cell u_cell (
                .clk        (clk),
                .ctl        (cell_ctl),
                .new_ent    (new_ent),
                .prev_ent   (new_ent),
                .prev_valid (1'b1),
                .prev_gt    (1'b0),
                .next_ent   (ent[(i + 1) % N]),
                .valid      (valid[i]),
                .ent        (ent[i]),
                .gt         (gt[i])
            );
        end
        else
        begin : g_body
            cmap_rc_cell u_cell (
                .clk        (clk),
                .ctl        (cell_ctl),
                .new_ent    (new_ent),
                .prev_ent   (ent[i-1]),
                .prev_valid (valid[i-1]),
                .prev_gt    (gt[i-1]),
                .next_ent   (ent[(i + 1) % N]),
                .valid      (valid[i]),
                .ent        (ent[i]),
                .gt         (gt[i])
            );
        end
    end

    // walk step decode
    range_ent_t         head;
    logic               cur_le_e;
    logic               walk_live;
    logic               skip;
    logic               stop;
    logic               gap;
    logic               pc_v;
    logic [CP_W-1:0]    pc_start;
    logic [CP_W-1:0]    pc_end;
    logic               keep_ok;
    logic               piece_v;
    logic [GLYPH_W-1:0] pc_glyph;
    logic [RO_W-1:0]    pc_ro;

    assign head      = ent[0];
    assign cur_le_e  = (cur_reg <= {1'b0, e_reg});
    assign walk_live = !done_reg && (idx_reg < count_reg) && cur_le_e;
    assign skip      = ({1'b0, head.last_cp} < cur_reg);
    assign stop      = (head.first_cp > e_reg);
    assign gap       = ({1'b0, head.first_cp} > cur_reg);
    assign pc_start  = cur_reg[CP_W-1:0];

    always_comb
    begin
        if (state_reg == ST_WALK)
        begin
            pc_v   = walk_live && !skip && !stop && gap;
            pc_end = head.first_cp - CP_W'(1);
        end
        else
        begin
            pc_v   = (state_reg == ST_TAIL) && cur_le_e;
            pc_end = e_reg;
        end
    end

    // format 4 with a range offset keeps only the piece at the segment start
    assign keep_ok = (func_reg == FUNC_CLIP12) || (ro_reg == '0) || (pc_start == s_reg);
    assign piece_v = pc_v && keep_ok;
    assign pc_glyph = (func_reg == FUNC_CLIP12)
                    ? g_reg + GLYPH_W'(pc_start - s_reg)
                    : {{(GLYPH_W-16){1'b0}}, g_reg[15:0]};
    assign pc_ro    = (func_reg == FUNC_CLIP12) ? '0 : ro_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        done_next       = done_reg;
        func_next       = func_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        g_next          = g_reg;
        ro_next         = ro_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        pend_glyph_next = pend_glyph_reg;
        pend_ro_next    = pend_ro_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_glyph_next  = out_glyph_reg;
        out_ro_next     = out_ro_reg;
        out_kept_next   = out_kept_reg;
        out_last_next   = out_last_reg;
        out_drop_next   = out_drop_reg;

        // a new piece pushes the held one out; the held one tells if it is last
        if (((state_reg == ST_WALK) || (state_reg == ST_TAIL)) && can_emit && piece_v)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_start_next = pend_start_reg;
                out_end_next   = pend_end_reg;
                out_glyph_next = pend_glyph_reg;
                out_ro_next    = pend_ro_reg;
                out_kept_next  = 1'b1;
                out_last_next  = 1'b0;
                out_drop_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_start_next = pc_start;
            pend_end_next   = pc_end;
            pend_glyph_next = pc_glyph;
            pend_ro_next    = pc_ro;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    func_next       = in_func;
                    s_next          = in_start;
                    e_next          = in_end;
                    g_next          = in_glyph;
                    ro_next         = in_ro;
                    cur_next        = {1'b0, in_start};
                    idx_next        = '0;
                    done_next       = 1'b0;
                    pend_valid_next = 1'b0;
                    out_start_next  = '0;
                    out_end_next    = '0;
                    out_glyph_next  = '0;
                    out_ro_next     = '0;
                    out_kept_next   = 1'b0;
                    out_last_next   = 1'b1;
                    out_drop_next   = 1'b0;
                    case (in_func)
                        FUNC_CLEAR:
                        begin
                            count_next     = '0;
                            out_valid_next = 1'b1;
                        end
                        FUNC_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                out_drop_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                            state_next = ST_WALK;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (can_emit)
                begin
                    idx_next = idx_reg + CW'(1);
                    if (walk_live && !skip)
                    begin
                        if (stop)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            cur_next = {1'b0, head.last_cp} + (CP_W+1)'(1);
                        end
                    end
                    if (idx_reg == CW'(N - 1))
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL:
            begin
                if (can_emit)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_drop_next  = 1'b0;
                    out_kept_next  = pend_valid_reg;
                    out_start_next = pend_valid_reg ? pend_start_reg : '0;
                    out_end_next   = pend_valid_reg ? pend_end_reg : '0;
                    out_glyph_next = pend_valid_reg ? pend_glyph_reg : '0;
                    out_ro_next    = pend_valid_reg ? pend_ro_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        func_reg       <= func_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        g_reg          <= g_next;
        ro_reg         <= ro_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        pend_glyph_reg <= pend_glyph_next;
        pend_ro_reg    <= pend_ro_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_glyph_reg  <= out_glyph_next;
        out_ro_reg     <= out_ro_next;
        out_kept_reg   <= out_kept_next;
        out_last_reg   <= out_last_next;
        out_drop_reg   <= out_drop_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-2*CP_W-GLYPH_W-RO_W){1'b0}},
                            out_ro_reg, out_glyph_reg, out_end_reg, out_start_reg};
    assign m_axis_tuser  = {out_drop_reg, out_kept_reg};
    assign m_axis_tlast  = out_last_reg;

    // checks

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("range count above table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_func == FUNC_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_func == FUNC_ADD) && full)
        |=> (m_axis_tvalid && m_axis_tuser[1] && m_axis_tlast && $stable(count_reg)))
        else $error("add on a full table not flagged as dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (idx_reg < CW'(N)))
        else $error("walk index past the chain");

endmodule

`default_nettype wire
